[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the text renderer's byte serializer (tto_back)
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(label, clk_sig, rst_sig, prop) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error("assertion failed: label");

// implication checked on the next clock edge outside reset
`define ASSERT_NEXT(label, clk_sig, rst_sig, cond, prop) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond) |=> (prop)) \
    else $error("assertion failed: label");

`endif

[rtl/tto_pkg.sv]
// ----------------------------------------------------------------------------
// tto_pkg
// Shared types, constants and the 5x8 font table of the text renderer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tto_pkg;

  // geometry defaults
  localparam int DISPLAY_COLUMNS_DEFAULT = 128;
  localparam int LAST_PAGE_DEFAULT       = 7;
  localparam int GLYPH_WIDTH             = 5;
  localparam int GLYPH_COUNT             = 95;
  localparam int CMD_COUNT               = 6;
  localparam int MAX_BYTES               = GLYPH_WIDTH + CMD_COUNT;
  localparam int QUEUE_DEPTH             = 4;

  // field widths
  localparam int CHAR_BITS  = 8;
  localparam int COL_BITS   = 7;
  localparam int PAGE_BITS  = 3;
  localparam int GLYPH_BITS = 7;
  localparam int STEP_BITS  = 4;

  // character codes
  localparam logic [CHAR_BITS-1:0] CHAR_END     = 8'h00;
  localparam logic [CHAR_BITS-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_BITS-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_BITS-1:0] CHAR_TILDE   = 8'h7E;

  // display command opcodes
  localparam logic [7:0] CMD_COLUMN_RANGE = 8'h21;
  localparam logic [7:0] CMD_PAGE_RANGE   = 8'h22;

  // one unit of work handed from front to back
  typedef struct packed {
    logic                  newline;
    logic [GLYPH_BITS-1:0] glyph;
    logic                  wrap;
    logic [PAGE_BITS-1:0]  page;
  } job_t;

  // font rows, leftmost column in the top byte
  localparam logic [39:0] FONT [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00002f0000, 40'h0007000700,
    40'h147f147f14, 40'h242a7f2a12, 40'h2313086462,
    40'h3649552250, 40'h0005030000, 40'h001c224100,
    40'h0041221c00, 40'h14083E0814, 40'h08083E0808,
    40'h0000A06000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
    40'h4261514946, 40'h2141454B31, 40'h1814127F10,
    40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000,
    40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324959513E,
    40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
    40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
    40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
    40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
    40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
    40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h55AA55AA55, 40'h0041417F00, 40'h0402010204,
    40'h4040404040, 40'h0003050000, 40'h2054545478,
    40'h7F48444438, 40'h3844444420, 40'h384444487F,
    40'h3854545418, 40'h087E090102, 40'h18A4A4A47C,
    40'h7F08040478, 40'h00447D4000, 40'h4080847D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
    40'h7C08040478, 40'h3844444438, 40'hFC24242418,
    40'h18242418FC, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
    40'h3C4030403C, 40'h4428102844, 40'h1CA0A0A07C,
    40'h4464544C44, 40'h00107C8200, 40'h0000FF0000,
    40'h00827C1000, 40'h0006090906
  };

  // one column byte of a glyph
  function automatic logic [7:0] font_column(input logic [GLYPH_BITS-1:0] glyph,
                                             input logic [2:0] col);
    logic [39:0] row;
    row = FONT[glyph];
    case (col)
      3'd0:    font_column = row[39:32];
      3'd1:    font_column = row[31:24];
      3'd2:    font_column = row[23:16];
      3'd3:    font_column = row[15:8];
      3'd4:    font_column = row[7:0];
      default: font_column = 8'h00;
    endcase
  endfunction

endpackage

[rtl/text_to_oled_byte_stream.sv]
// ----------------------------------------------------------------------------
// text_to_oled_byte_stream
// Text renderer producing command and glyph bytes for a page-addressed OLED
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Each text byte pushed in becomes a burst of display bytes popped out, one
// byte per clock while pop is held: five glyph bytes for a printable
// character (unprintable bytes draw as a space), six cursor command bytes for
// a newline, and eleven when a glyph fills the line and the cursor wraps. A
// zero byte is taken and gives nothing. The serializer in the back end emits
// one byte per cycle into an output register, stalling while the held byte
// is not popped; the input side takes one character per cycle until the
// four-entry job queue between front and back fills. The last flag marks
// the final byte of each character's burst. No clearing pass after reset.

module text_to_oled_byte_stream #(
  parameter int DISPLAY_COLUMNS = tto_pkg::DISPLAY_COLUMNS_DEFAULT,
  parameter int LAST_PAGE       = tto_pkg::LAST_PAGE_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [tto_pkg::CHAR_BITS-1:0] character,
  output logic                          empty,
  input  logic                          pop,
  output logic                          is_command,
  output logic [7:0]                    byte_value,
  output logic                          last
);

  tto_pkg::job_t new_job;
  tto_pkg::job_t head_job;
  logic          job_push;
  logic          queue_full;
  logic          head_valid;
  logic          job_done;

  // classification and cursor
  tto_front #(
    .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
    .LAST_PAGE       (LAST_PAGE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .character  (character),
    .queue_full (queue_full),
    .full       (full),
    .job_push   (job_push),
    .job        (new_job)
  );

  // job queue
  tto_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (job_push),
    .wr_job     (new_job),
    .rd_en      (job_done),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // byte serializer
  tto_back #(
    .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
    .LAST_PAGE       (LAST_PAGE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .job_done   (job_done),
    .empty      (empty),
    .pop        (pop),
    .is_command (is_command),
    .byte_value (byte_value),
    .last       (last)
  );

endmodule

[rtl/tto_front.sv]
// ----------------------------------------------------------------------------
// tto_front
// Accepts text bytes, classifies them and advances the cursor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tto_front #(
  parameter int DISPLAY_COLUMNS = tto_pkg::DISPLAY_COLUMNS_DEFAULT,
  parameter int LAST_PAGE       = tto_pkg::LAST_PAGE_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [tto_pkg::CHAR_BITS-1:0]  character,
  input  logic                           queue_full,
  output logic                           full,
  output logic                           job_push,
  output tto_pkg::job_t                  job
);

  localparam logic [7:0] COL_STEP  = 8'(tto_pkg::GLYPH_WIDTH + 1);
  localparam logic [7:0] COL_LIMIT = 8'(DISPLAY_COLUMNS - tto_pkg::GLYPH_WIDTH);
  localparam logic [tto_pkg::PAGE_BITS-1:0] PAGE_MAX = tto_pkg::PAGE_BITS'(LAST_PAGE);

  logic [tto_pkg::COL_BITS-1:0]  cursor_column;
  logic [tto_pkg::COL_BITS-1:0]  cursor_column_next;
  logic [tto_pkg::PAGE_BITS-1:0] cursor_page;
  logic [tto_pkg::PAGE_BITS-1:0] cursor_page_next;
  logic [tto_pkg::PAGE_BITS-1:0] page_advanced;
  logic [7:0]                    col_sum;
  logic [tto_pkg::CHAR_BITS-1:0] glyph_offset;
  logic                          accept;
  logic                          is_newline;
  logic                          is_printable;
  logic                          line_full;

  assign full   = queue_full;
  assign accept = push && !queue_full;

  // classify the incoming byte
  always_comb begin
    is_newline   = (character == tto_pkg::CHAR_NEWLINE);
    is_printable = character inside {[tto_pkg::CHAR_SPACE:tto_pkg::CHAR_TILDE]};
    glyph_offset = is_printable ? (character - tto_pkg::CHAR_SPACE) : '0;
  end

  // cursor arithmetic
  always_comb begin
    col_sum       = {1'b0, cursor_column} + COL_STEP;
    line_full     = (col_sum >= COL_LIMIT);
    page_advanced = (cursor_page >= PAGE_MAX) ? '0 : cursor_page + 1'b1;
  end

  // job for the back end
  always_comb begin
    job_push    = accept && (character != tto_pkg::CHAR_END);
    job.newline = is_newline;
    job.glyph   = glyph_offset[tto_pkg::GLYPH_BITS-1:0];
    job.wrap    = is_newline || line_full;
    job.page    = page_advanced;
  end

  // cursor update on each transfer
  always_comb begin
    cursor_column_next = cursor_column;
    cursor_page_next   = cursor_page;
    if (job_push) begin
      if (is_newline || line_full) begin
        cursor_column_next = '0;
        cursor_page_next   = page_advanced;
      end else begin
        cursor_column_next = col_sum[tto_pkg::COL_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_page   <= '0;
    end else begin
      cursor_column <= cursor_column_next;
      cursor_page   <= cursor_page_next;
    end
  end

endmodule

[rtl/tto_queue.sv]
// ----------------------------------------------------------------------------
// tto_queue
// Short job queue between the front end and the byte serializer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tto_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  tto_pkg::job_t wr_job,
  input  logic          rd_en,
  output logic          full,
  output logic          head_valid,
  output tto_pkg::job_t head_job
);

  localparam int DEPTH = tto_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  tto_pkg::job_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];
  assign do_wr      = wr_en && !full;
  assign do_rd      = rd_en && head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/tto_back.sv]
// ----------------------------------------------------------------------------
// tto_back
// Serializes each job into glyph and cursor command bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tto_back #(
  parameter int DISPLAY_COLUMNS = tto_pkg::DISPLAY_COLUMNS_DEFAULT,
  parameter int LAST_PAGE       = tto_pkg::LAST_PAGE_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  tto_pkg::job_t head_job,
  output logic          job_done,
  output logic          empty,
  input  logic          pop,
  output logic          is_command,
  output logic [7:0]    byte_value,
  output logic          last
);

  localparam int SW = tto_pkg::STEP_BITS;

  // positions within the cursor command sequence
  localparam logic [2:0] SEL_COL_OP    = 3'd0;
  localparam logic [2:0] SEL_COL_START = 3'd1;
  localparam logic [2:0] SEL_COL_END   = 3'd2;
  localparam logic [2:0] SEL_PAGE_OP   = 3'd3;
  localparam logic [2:0] SEL_PAGE_CUR  = 3'd4;
  localparam logic [2:0] SEL_PAGE_END  = 3'd5;

  localparam logic [SW-1:0] GLYPH_LAST = SW'(tto_pkg::GLYPH_WIDTH - 1);
  localparam logic [SW-1:0] CMD_LAST   = SW'(tto_pkg::CMD_COUNT - 1);
  localparam logic [SW-1:0] WRAP_LAST  = SW'(tto_pkg::MAX_BYTES - 1);
  localparam logic [SW-1:0] CMD_BASE   = SW'(tto_pkg::GLYPH_WIDTH);

  logic [SW-1:0] step;
  logic [SW-1:0] cmd_pos;
  logic [2:0]    cmd_sel;
  logic [7:0]    cmd_byte;
  logic [7:0]    byte_next;
  logic          cmd_next;
  logic          last_next;
  logic          out_valid;
  logic          advance;

  assign empty   = !out_valid;
  assign advance = head_valid && (!out_valid || pop);

  // which command byte this step gives
  always_comb begin
    cmd_pos = head_job.newline ? step : step - CMD_BASE;
    cmd_sel = cmd_pos[2:0];
    case (cmd_sel)
      SEL_COL_OP:    cmd_byte = tto_pkg::CMD_COLUMN_RANGE;
      SEL_COL_START: cmd_byte = 8'h00;
      SEL_COL_END:   cmd_byte = 8'(DISPLAY_COLUMNS - 1);
      SEL_PAGE_OP:   cmd_byte = tto_pkg::CMD_PAGE_RANGE;
      SEL_PAGE_CUR:  cmd_byte = {5'b0, head_job.page};
      SEL_PAGE_END:  cmd_byte = 8'(LAST_PAGE);
      default:       cmd_byte = 8'h00;
    endcase
  end

  // byte for the current step
  always_comb begin
    if (head_job.newline) begin
      cmd_next  = 1'b1;
      byte_next = cmd_byte;
      last_next = (step == CMD_LAST);
    end else if (step <= GLYPH_LAST) begin
      cmd_next  = 1'b0;
      byte_next = tto_pkg::font_column(head_job.glyph, step[2:0]);
      last_next = !head_job.wrap && (step == GLYPH_LAST);
    end else begin
      cmd_next  = 1'b1;
      byte_next = cmd_byte;
      last_next = (step == WRAP_LAST);
    end
  end

  assign job_done = advance && last_next;

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (advance) begin
      step <= last_next ? '0 : step + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      is_command <= cmd_next;
      byte_value <= byte_next;
      last       <= last_next;
    end
  end

  // checks
  `ASSERT_CLK(a_step_range, clk, rst, step <= WRAP_LAST)
  `ASSERT_CLK(a_newline_steps, clk, rst, !(head_valid && head_job.newline) || step <= CMD_LAST)
  `ASSERT_NEXT(a_glyph_is_data, clk, rst, advance && !head_job.newline && step <= GLYPH_LAST, out_valid && !is_command)

endmodule
